// ===== rtl/core/cfr_pkg.sv =====
// cfr_pkg: shared types and constants of the command frame receiver
// depends on nothing; used by all rtl/core modules
`default_nettype none

package cfr_pkg;

    localparam int DATA_FRAME_BYTES = 36;
    localparam int CMD_FRAME_BYTES  = 5;
    localparam int PAYLOAD_BYTES    = 32;
    localparam int POS_W            = 6;

    localparam logic [7:0] HDR_CMD  = 8'hAA;
    localparam logic [7:0] HDR_DATA = 8'hAB;
    localparam logic [7:0] FOOT_A   = 8'h0D;
    localparam logic [7:0] FOOT_B   = 8'h0A;
    localparam logic [7:0] OP_SIT   = 8'h20;
    localparam logic [7:0] OP_SUT   = 8'h22;
    localparam logic [7:0] OP_STOP  = 8'h24;
    localparam logic [7:0] TAB_SIT  = 8'h8C;
    localparam logic [7:0] TAB_SUT  = 8'h8E;
    localparam logic [7:0] TAB_STOP = 8'h90;

    typedef enum logic [2:0] {
        EV_BAD_FOOTER = 3'd0,
        EV_UNKNOWN    = 3'd1,
        EV_BAD_CMDCKS = 3'd2,
        EV_SIT        = 3'd3,
        EV_SUT        = 3'd4,
        EV_STOP       = 3'd5,
        EV_DATA_OK    = 3'd6,
        EV_DATA_CKS   = 3'd7
    } t_event;

    typedef enum logic [1:0] {
        MODE_STOP = 2'd0,
        MODE_SIT  = 2'd1,
        MODE_SUT  = 2'd2
    } t_mode;

    typedef struct packed {
        logic       done;
        logic       foot_ok;
        logic       long_frame;
        logic [7:0] op;
        logic [7:0] cks;
        logic [7:0] sum;
    } t_frame_end;

endpackage

`default_nettype wire

// ===== rtl/core/cfr_if.sv =====
// cfr_if: valid/ready channel interfaces for received bytes and frame results
// depends on nothing
`default_nettype none

interface cfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [1:0]  mode_now;
    logic [31:0] altitude_word;
    logic [31:0] pressure_word;
    logic [31:0] accel_x_word;
    logic [31:0] accel_y_word;
    logic [31:0] accel_z_word;
    logic [31:0] angle_x_word;
    logic [31:0] angle_y_word;
    logic [31:0] angle_z_word;
    logic [31:0] accepted_count;
    logic [31:0] error_count;

    modport source (output valid, output event_res, output mode_now,
        output altitude_word, output pressure_word, output accel_x_word,
        output accel_y_word, output accel_z_word, output angle_x_word,
        output angle_y_word, output angle_z_word, output accepted_count,
        output error_count, input ready);
    modport sink (input valid, input event_res, input mode_now,
        input altitude_word, input pressure_word, input accel_x_word,
        input accel_y_word, input accel_z_word, input angle_x_word,
        input angle_y_word, input angle_z_word, input accepted_count,
        input error_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cfr_track.sv =====
// cfr_track: frame position tracking, field capture, payload shift line, running sum
// depends on cfr_pkg
`default_nettype none

module cfr_track (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic [7:0]            i_byte,
    input  wire logic [1:0]            i_mode,
    output cfr_pkg::t_frame_end        o_end,
    output logic [8*cfr_pkg::PAYLOAD_BYTES-1:0] o_payload
);
    import cfr_pkg::*;

    localparam logic [POS_W-1:0] POS_CKS_L  = POS_W'(DATA_FRAME_BYTES - 3);
    localparam logic [POS_W-1:0] POS_FOOT_L = POS_W'(DATA_FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_LAST_L = POS_W'(DATA_FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_CKS_S  = POS_W'(CMD_FRAME_BYTES - 3);
    localparam logic [POS_W-1:0] POS_FOOT_S = POS_W'(CMD_FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_LAST_S = POS_W'(CMD_FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_PAY_END = POS_W'(PAYLOAD_BYTES);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_long, n_long;
    logic [7:0]       r_op, r_cks, r_foot, r_sum;
    logic [8*PAYLOAD_BYTES-1:0] r_pay;

    logic last, in_frame, in_pay;
    logic [POS_W-1:0] cks_pos, foot_pos;

    assign in_frame = (r_pos != '0);
    assign last     = r_long ? (r_pos == POS_LAST_L) : (r_pos == POS_LAST_S);
    assign cks_pos  = r_long ? POS_CKS_L : POS_CKS_S;
    assign foot_pos = r_long ? POS_FOOT_L : POS_FOOT_S;
    assign in_pay   = r_long && in_frame && (r_pos <= POS_PAY_END);

    always_comb begin
        n_pos  = r_pos;
        n_long = r_long;
        if (!in_frame) begin
            if (i_byte == HDR_CMD) begin
                n_pos  = POS_W'(1);
                n_long = 1'b0;
            end else if (i_byte == HDR_DATA && i_mode == MODE_SUT) begin
                n_pos  = POS_W'(1);
                n_long = 1'b1;
            end
        end else if (last) begin
            n_pos  = '0;
            n_long = 1'b0;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_long <= 1'b0;
        end else if (i_step) begin
            r_pos  <= n_pos;
            r_long <= n_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && in_frame) begin
            if (!r_long && r_pos == POS_W'(1)) begin
                r_op <= i_byte;
            end
            if (r_pos == cks_pos) begin
                r_cks <= i_byte;
            end
            if (r_pos == foot_pos) begin
                r_foot <= i_byte;
            end
            if (in_pay) begin
                r_pay <= {r_pay[8*PAYLOAD_BYTES-9:0], i_byte};
                r_sum <= (r_pos == POS_W'(1)) ? i_byte : r_sum + i_byte;
            end
        end
    end

    assign o_end.done       = i_step && in_frame && last;
    assign o_end.foot_ok    = (r_foot == FOOT_A) && (i_byte == FOOT_B);
    assign o_end.long_frame = r_long;
    assign o_end.op         = r_op;
    assign o_end.cks        = r_cks;
    assign o_end.sum        = r_sum;
    assign o_payload        = r_pay;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST_L)
        else $error("frame position beyond data frame");
    a_short_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_long |-> r_pos <= POS_LAST_S)
        else $error("command frame position beyond command frame");
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_end.done |=> r_pos == '0 && !r_long)
        else $error("tracker did not return to idle after frame end");
    a_long_needs_sut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !in_frame && n_long |-> i_mode == MODE_SUT)
        else $error("data frame opened outside SUT mode");

endmodule

`default_nettype wire

// ===== rtl/core/cfr_decide.sv =====
// cfr_decide: frame verdict, mode register, packet counters and result register
// depends on cfr_pkg and cfr_out_if
`default_nettype none

module cfr_decide (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire cfr_pkg::t_frame_end   i_end,
    input  wire logic [8*cfr_pkg::PAYLOAD_BYTES-1:0] i_payload,
    output logic [1:0]                 o_mode,
    cfr_out_if.source                  o_res
);
    import cfr_pkg::*;

    t_mode       r_mode, n_mode;
    t_event      n_ev;
    logic        r_valid;
    logic [2:0]  r_ev;
    logic [31:0] r_acc, r_err;
    logic [8*PAYLOAD_BYTES-1:0] r_words;
    logic [7:0]  tab, plain;
    logic        cmd_known, data_ok;
    t_mode       cmd_mode;
    t_event      cmd_ev;

    assign plain   = HDR_CMD + i_end.op;
    assign data_ok = (i_end.cks == i_end.sum) || (i_end.cks == 8'(i_end.sum + HDR_DATA));

    always_comb begin
        tab       = TAB_STOP;
        cmd_mode  = MODE_STOP;
        cmd_ev    = EV_UNKNOWN;
        cmd_known = 1'b1;
        case (i_end.op)
            OP_SIT: begin
                tab = TAB_SIT;  cmd_mode = MODE_SIT;  cmd_ev = EV_SIT;
            end
            OP_SUT: begin
                tab = TAB_SUT;  cmd_mode = MODE_SUT;  cmd_ev = EV_SUT;
            end
            OP_STOP: begin
                tab = TAB_STOP; cmd_mode = MODE_STOP; cmd_ev = EV_STOP;
            end
            default: begin
                cmd_known = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mode = r_mode;
        if (!i_end.foot_ok) begin
            n_ev = EV_BAD_FOOTER;
        end else if (!i_end.long_frame) begin
            if (!cmd_known) begin
                n_ev = EV_UNKNOWN;
            end else if (i_end.cks != plain && i_end.cks != tab) begin
                n_ev = EV_BAD_CMDCKS;
            end else begin
                n_ev   = cmd_ev;
                n_mode = cmd_mode;
            end
        end else if (data_ok) begin
            n_ev = EV_DATA_OK;
        end else begin
            n_ev = EV_DATA_CKS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_STOP;
            r_valid <= 1'b0;
            r_acc   <= '0;
            r_err   <= '0;
        end else if (i_end.done) begin
            r_mode  <= n_mode;
            r_valid <= 1'b1;
            if (n_ev == EV_DATA_OK) begin
                r_acc <= r_acc + 32'd1;
            end
            if (n_ev == EV_DATA_CKS) begin
                r_err <= r_err + 32'd1;
            end
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_end.done) begin
            r_ev    <= n_ev;
            r_words <= (n_ev == EV_DATA_OK) ? i_payload : '0;
        end
    end

    assign o_mode               = r_mode;
    assign o_res.valid          = r_valid;
    assign o_res.event_res      = r_ev;
    assign o_res.mode_now       = r_mode;
    assign o_res.altitude_word  = r_words[255:224];
    assign o_res.pressure_word  = r_words[223:192];
    assign o_res.accel_x_word   = r_words[191:160];
    assign o_res.accel_y_word   = r_words[159:128];
    assign o_res.accel_z_word   = r_words[127:96];
    assign o_res.angle_x_word   = r_words[95:64];
    assign o_res.angle_y_word   = r_words[63:32];
    assign o_res.angle_z_word   = r_words[31:0];
    assign o_res.accepted_count = r_acc;
    assign o_res.error_count    = r_err;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_end.done |-> !r_valid || o_res.ready)
        else $error("result overwritten before it was taken");
    a_one_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_acc != $past(r_acc) && r_err != $past(r_err)))
        else $error("both counters moved on one frame");
    a_acc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_end.done |=> $stable(r_acc) && $stable(r_err) && $stable(r_mode))
        else $error("state changed without a frame end");
    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_STOP || r_mode == MODE_SIT || r_mode == MODE_SUT)
        else $error("mode register holds an unused code");

endmodule

`default_nettype wire

// ===== rtl/core/command_frame_receiver_top.sv =====
// command_frame_receiver_top: byte input register, frame tracker and verdict stage
// depends on cfr_pkg, cfr_if, cfr_track, cfr_decide
//
//  port    dir  contents                                   handshake
//  i_rx    in   rx_byte, one byte from the serial line     valid/ready
//  o_res   out  event, mode, eight payload words, counters valid/ready
//
// one byte per cycle while the result register is not held full; a result
// follows the byte that ends its frame via input register, then result register
// the result register holds until taken; while it is full and not taken,
// every byte waits in the input register and input ready drops
// synchronous active-low reset returns to stop mode with counters at zero
`default_nettype none

module command_frame_receiver_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cfr_in_if.sink    i_rx,
    cfr_out_if.source o_res
);
    import cfr_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       step;
    logic [1:0] mode;
    t_frame_end frame_end;
    logic [8*PAYLOAD_BYTES-1:0] payload;

    assign step       = r_in_valid && (!o_res.valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    cfr_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_in_byte),
        .i_mode    (mode),
        .o_end     (frame_end),
        .o_payload (payload)
    );

    cfr_decide u_decide (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_end     (frame_end),
        .i_payload (payload),
        .o_mode    (mode),
        .o_res     (o_res)
    );

    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !step |=> r_in_valid && $stable(r_in_byte))
        else $error("stalled input byte was lost");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_rx.ready)
        else $error("input blocked with empty input register");
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_end.done |=> o_res.valid)
        else $error("frame end produced no result");

endmodule

`default_nettype wire
